/* sv/mlb_pkg.sv */
// Shared constants, types and elaboration-time tables for the morphing LFO bank.
// Depends on nothing; the bank, the 2^x unit and the testbench refer to it by scoped names.
package mlb_pkg;

	// Bank geometry
	localparam int VOICES           = 16;
	localparam int SINE_TABLE_DEPTH = 1024;
	localparam int PHASE_BITS       = 32;

	localparam int VOICE_AW  = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int SIN_BITS  = $clog2(SINE_TABLE_DEPTH);
	localparam int EXP_STEPS = 12;
	localparam int CNT_W     = $clog2(EXP_STEPS);

	// Field widths
	localparam int INC_W   = 23;
	localparam int RATIO_W = 32;
	localparam int PROD_W  = INC_W + RATIO_W;

	// Configuration register indexes
	localparam int          CFG_IDX_W   = 1;
	localparam logic [0:0]  CFG_BIPOLAR = 1'b0;
	localparam logic [0:0]  CFG_INC     = 1'b1;
	localparam logic [22:0] INC_RESET   = 23'd89478;

	// Reset comparator thresholds, millivolts
	localparam int RST_HIGH = 2000;
	localparam int RST_LOW  = 100;

	// Quarter-sine polynomial, Q15
	localparam int SIN_A1 = 51472;
	localparam int SIN_A3 = 21024;
	localparam int SIN_A5 = 2320;

	// Integer square root, used only at elaboration
	function automatic logic [63:0] isqrt(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bt;
		logic [63:0] rem;
		res = '0;
		bt  = 64'd1 << 62;
		rem = v;
		while (bt > rem)
			bt = bt >> 2;
		while (bt != 0) begin
			if (rem >= res + bt) begin
				rem = rem - (res + bt);
				res = (res >> 1) + bt;
			end else begin
				res = res >> 1;
			end
			bt = bt >> 2;
		end
		return res;
	endfunction

	// Q30 roots 2^(2^b/4096), b = 0..11, packed 32 bits each
	function automatic logic [EXP_STEPS*RATIO_W-1:0] make_roots();
		logic [EXP_STEPS*RATIO_W-1:0] tab;
		logic [63:0] r;
		tab = '0;
		r = isqrt(64'd1 << 61);
		tab[(EXP_STEPS-1)*RATIO_W +: RATIO_W] = r[RATIO_W-1:0];
		for (int b = EXP_STEPS - 1; b > 0; b--) begin
			r = isqrt(r << 30);
			tab[(b-1)*RATIO_W +: RATIO_W] = r[RATIO_W-1:0];
		end
		return tab;
	endfunction

	localparam logic [EXP_STEPS*RATIO_W-1:0] ROOTS = make_roots();

endpackage

/* sv/mlb_in_if.sv */
// Request channel into the LFO bank: one sample tick for one voice.
// Depends on nothing.
interface mlb_in_if;
	logic               valid;
	logic               ready;
	logic [3:0]         voice;
	logic signed [17:0] pitch_octaves;
	logic [11:0]        wave_shape;
	logic [15:0]        pulse_width;
	logic [15:0]        phase_offset;
	logic signed [14:0] reset_level;

	modport source (output valid, voice, pitch_octaves, wave_shape, pulse_width,
		phase_offset, reset_level, input ready);
	modport sink (input valid, voice, pitch_octaves, wave_shape, pulse_width,
		phase_offset, reset_level, output ready);
endinterface

/* sv/mlb_out_if.sv */
// Result channel out of the LFO bank: one level per sample tick.
// Depends on nothing.
interface mlb_out_if;
	logic               valid;
	logic               ready;
	logic [3:0]         voice_out;
	logic signed [15:0] level;

	modport source (output valid, voice_out, level, input ready);
	modport sink (input valid, voice_out, level, output ready);
endinterface

/* sv/morphing_lfo_bank.sv */
// Morphing LFO bank: sixteen low-frequency oscillators sharing one datapath.
// A request names a voice and carries pitch, morph, pulse width, phase offset and
// reset level; each request gives one level in 1/2048 V. From acceptance to the
// output register a request waits on the serial 2^x unit (twelve multiply steps,
// one per pitch fraction bit, then the hand-over), forms the step product, writes
// the phase back to memory, runs the sine polynomial and the other waves in
// S_SIN1 to S_SIN4, forms the weighted mix on one multiplier, and loads the
// output register. A new request is taken in the cycle after the result reaches
// the output register, so the bank takes no request while one is in flight; a
// stalled result holds the bank until it is taken.
// Out-of-range voices skip to S_OUT and give level zero. No clearing pass after
// reset. Depends on mlb_pkg, mlb_in_if, mlb_out_if and mlb_exp2.
module morphing_lfo_bank (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mlb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mlb_pkg::INC_W-1:0]      cfg_data,
	mlb_in_if.sink                         in_req,
	mlb_out_if.source                      out_req
);

	localparam int PB = mlb_pkg::PHASE_BITS;
	localparam int SB = mlb_pkg::SIN_BITS;

	typedef enum logic [3:0] {
		S_IDLE, S_EXP, S_MUL, S_ADV, S_SIN1, S_SIN2, S_SIN3, S_SIN4, S_MIX, S_OUT
	} state_t;

	state_t state_q;

	// Configuration
	logic                      bipolar_q;
	logic [mlb_pkg::INC_W-1:0] inc_q;

	// Request fields
	logic [3:0]                   voice_q;
	logic                         voice_ok_q;
	logic [mlb_pkg::VOICE_AW-1:0] idx_q;
	logic [11:0]                  shape_q;
	logic [15:0]                  pw_q;
	logic [15:0]                  offs_q;
	logic [7:0]                   shift_q;
	logic                         zero_q;

	// State storage
	logic [PB-1:0]              phase_mem [mlb_pkg::VOICES];
	logic [PB-1:0]              rd_q;
	logic [mlb_pkg::VOICES-1:0] phase_vld_q;
	logic [mlb_pkg::VOICES-1:0] latch_q;

	// Datapath registers
	logic [mlb_pkg::PROD_W-1:0] t_q;
	logic [PB-1:0]              ph_q;
	logic [16:0]                x_q;
	logic                       neg_q;
	logic [16:0]                x2_q;
	logic [15:0]                inner_q;
	logic [15:0]                mid_q;
	logic signed [17:0]         wave_q [4];
	logic [1:0]                 mix_q;
	logic signed [27:0]         sum_q;
	logic                       out_valid_q;
	logic [3:0]                 out_voice_q;
	logic signed [15:0]         out_level_q;

	// exp2 unit
	logic                          exp_start;
	logic                          exp_done;
	logic [mlb_pkg::RATIO_W-1:0]   ratio;

	logic accept;
	assign accept        = in_req.valid && in_req.ready;
	assign in_req.ready  = (state_q == S_IDLE);

	// Pitch decode: saturate, split into octave and fraction
	logic signed [17:0] pitch_sat;
	logic [18:0]        pu;
	assign pitch_sat = (in_req.pitch_octaves > 18'sd40960) ? 18'sd40960 : in_req.pitch_octaves;
	assign pu        = 19'(pitch_sat) + 19'd131072;
	assign exp_start = accept && (32'(in_req.voice) < mlb_pkg::VOICES);

	mlb_exp2 u_exp2 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (exp_start),
		.frac   (pu[11:0]),
		.done   (exp_done),
		.ratio  (ratio)
	);

	logic [mlb_pkg::VOICE_AW-1:0] in_idx;
	logic                         rst_hi;
	logic                         rst_lo;
	assign in_idx = in_req.voice[mlb_pkg::VOICE_AW-1:0];
	assign rst_hi = in_req.reset_level >= 15'sd2000;
	assign rst_lo = in_req.reset_level <= 15'sd100;

	// Phase advance
	logic [mlb_pkg::PROD_W-1:0] delta_full;
	logic [PB-1:0]              delta;
	logic [PB-1:0]              base;
	logic [PB-1:0]              new_ph;
	assign delta_full = t_q >> shift_q;
	assign delta = (delta_full > mlb_pkg::PROD_W'(64'd1 << (PB - 1))) ?
		PB'(64'd1 << (PB - 1)) : delta_full[PB-1:0];
	assign base   = (phase_vld_q[idx_q] && !zero_q) ? rd_q : '0;
	assign new_ph = base + delta;

	// Wave shapes from the offset phase
	logic [PB-1:0]      ps;
	logic [SB-1:0]      sidx;
	logic [16:0]        xr;
	logic [16:0]        xs;
	logic [33:0]        xx;
	logic [15:0]        u;
	logic [15:0]        q;
	logic [16:0]        d;
	logic signed [17:0] tri_w;
	logic signed [17:0] saw_w;
	logic signed [17:0] sq_w;
	logic [15:0]        pw_c;
	assign ps   = bipolar_q ? ph_q : ph_q - PB'(64'd1 << (PB - 2));
	assign sidx = ps[PB-1 -: SB];
	assign xr   = 17'(sidx[SB-3:0]) << (17 - SB);
	assign xs   = sidx[SB-2] ? 17'd32768 - xr : xr;
	assign xx   = xs * xs;
	assign u    = ph_q[PB-1 -: 16];
	assign q    = bipolar_q ? u + 16'd16384 : u;
	assign d    = (q <= 16'd32768) ? 17'(q) : 17'd65536 - 17'(q);
	assign tri_w = $signed({1'b0, d} << 1) - 18'sd32768;
	assign saw_w = bipolar_q ? 18'(signed'(u)) : 18'(u) - 18'sd32768;
	assign pw_c  = (pw_q < 16'd655) ? 16'd655 : ((pw_q > 16'd64880) ? 16'd64880 : pw_q);
	assign sq_w  = (u < pw_c) ? 18'sd32768 : -18'sd32768;

	// Sine polynomial steps
	logic [32:0] p_in;
	logic [32:0] p_mid;
	logic [32:0] p_out;
	logic [16:0] sine_mag;
	logic signed [17:0] sine_s;
	assign p_in     = x2_q * 16'd2320;
	assign p_mid    = x2_q * inner_q;
	assign p_out    = x_q * mid_q;
	assign sine_mag = p_out[31:15];
	assign sine_s   = neg_q ? -$signed({1'b0, sine_mag}) : $signed({1'b0, sine_mag});

	// Morph weight and mix product
	logic [11:0]        shape_c;
	logic signed [13:0] shape_span;
	logic signed [13:0] wraw;
	logic signed [11:0] wgt;
	logic signed [29:0] mprod;
	logic signed [30:0] xo;
	assign shape_c = (shape_q > 12'd3072) ? 12'd3072 : shape_q;
	assign shape_span = $signed({2'b0, shape_c}) - $signed({2'b0, mix_q, 10'd0});
	assign wraw  = 14'sd1024 - ((shape_span < 0) ? -shape_span : shape_span);
	assign wgt   = (wraw > 0) ? 12'(wraw) : 12'sd0;
	assign mprod = wgt * wave_q[mix_q];
	assign xo    = (31'(sum_q) <<< 2) + 31'(sum_q) + 31'sd8192;

	// Phase memory and request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q    <= phase_mem[in_idx];
			voice_q <= in_req.voice;
			idx_q   <= in_idx;
			shape_q <= in_req.wave_shape;
			pw_q    <= in_req.pulse_width;
			offs_q  <= in_req.phase_offset;
			shift_q <= 8'(94 - PB) - 8'(pu[18:12]);
			zero_q  <= rst_hi && !latch_q[in_idx];
		end
		if (state_q == S_ADV)
			phase_mem[idx_q] <= new_ph;
	end

	// Sequencer, configuration and per-voice flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			bipolar_q   <= 1'b0;
			inc_q       <= mlb_pkg::INC_RESET;
			phase_vld_q <= '0;
			latch_q     <= '1;
			out_valid_q <= 1'b0;
			voice_ok_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					mlb_pkg::CFG_BIPOLAR: bipolar_q <= cfg_data[0];
					mlb_pkg::CFG_INC:     inc_q     <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid_q && out_req.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						voice_ok_q <= exp_start;
						sum_q      <= '0;
						mix_q      <= '0;
						if (exp_start) begin
							if (rst_hi)
								latch_q[in_idx] <= 1'b1;
							else if (rst_lo)
								latch_q[in_idx] <= 1'b0;
							state_q <= S_EXP;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_EXP: if (exp_done) state_q <= S_MUL;
				S_MUL: begin
					t_q     <= inc_q * ratio;
					state_q <= S_ADV;
				end
				S_ADV: begin
					phase_vld_q[idx_q] <= 1'b1;
					ph_q    <= new_ph + (PB'(offs_q) << (PB - 16));
					state_q <= S_SIN1;
				end
				S_SIN1: begin
					x_q       <= xs;
					neg_q     <= sidx[SB-1];
					x2_q      <= xx[31:15];
					wave_q[1] <= bipolar_q ? tri_w : tri_w + 18'sd32768;
					wave_q[2] <= bipolar_q ? saw_w : saw_w + 18'sd32768;
					wave_q[3] <= bipolar_q ? sq_w : sq_w + 18'sd32768;
					state_q   <= S_SIN2;
				end
				S_SIN2: begin
					inner_q <= 16'd21024 - p_in[30:15];
					state_q <= S_SIN3;
				end
				S_SIN3: begin
					mid_q   <= 16'd51472 - p_mid[30:15];
					state_q <= S_SIN4;
				end
				S_SIN4: begin
					wave_q[0] <= bipolar_q ? sine_s : sine_s + 18'sd32768;
					state_q   <= S_MIX;
				end
				S_MIX: begin
					sum_q <= sum_q + 28'(mprod);
					mix_q <= mix_q + 1'b1;
					if (mix_q == 2'd3)
						state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || out_req.ready) begin
						out_valid_q <= 1'b1;
						out_voice_q <= voice_q;
						out_level_q <= voice_ok_q ? 16'(xo >>> 14) : 16'sd0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_req.valid     = out_valid_q;
	assign out_req.voice_out = out_voice_q;
	assign out_req.level     = out_level_q;

endmodule

/* sv/mlb_exp2.sv */
// Iterative 2^(f/4096) in Q30: a rounded multiply by a stored root per set bit.
// Depends on mlb_pkg (root table, widths).
module mlb_exp2 (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [mlb_pkg::EXP_STEPS-1:0] frac,
	output logic                          done,
	output logic [mlb_pkg::RATIO_W-1:0]   ratio
);

	logic [mlb_pkg::RATIO_W-1:0]   ratio_q;
	logic [mlb_pkg::EXP_STEPS-1:0] frac_q;
	logic [mlb_pkg::CNT_W-1:0]     cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [mlb_pkg::RATIO_W-1:0]   root;
	logic [2*mlb_pkg::RATIO_W-1:0] prod;

	// Root for the current bit, rounded product
	assign root = mlb_pkg::ROOTS[cnt_q*mlb_pkg::RATIO_W +: mlb_pkg::RATIO_W];
	assign prod = ratio_q * root + (64'd1 << 29);

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == mlb_pkg::CNT_W'(mlb_pkg::EXP_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// Accumulator
	always_ff @(posedge clk) begin
		if (start) begin
			ratio_q <= mlb_pkg::RATIO_W'(64'd1 << 30);
			frac_q  <= frac;
		end else if (busy_q && frac_q[cnt_q]) begin
			ratio_q <= prod[30 +: mlb_pkg::RATIO_W];
		end
	end

	assign done  = done_q;
	assign ratio = ratio_q;

endmodule

/* tb/morphing_lfo_bank_tb.sv */
// Self-checking testbench for morphing_lfo_bank: random and directed sample ticks,
// predicted levels compared against the result channel, with bursty traffic.
// Depends on mlb_pkg, mlb_in_if, mlb_out_if and the morphing_lfo_bank RTL.
module morphing_lfo_bank_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 5000;

	typedef struct {
		logic [3:0]         voice;
		logic signed [17:0] pitch;
		logic [11:0]        shape;
		logic [15:0]        pw;
		logic [15:0]        offs;
		logic signed [14:0] rst_mv;
	} tick_t;

	typedef struct {
		logic [3:0]         voice;
		logic signed [15:0] level;
	} level_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [mlb_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [mlb_pkg::INC_W-1:0]     cfg_data;

	mlb_in_if  in_bus();
	mlb_out_if out_bus();

	morphing_lfo_bank u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_req    (in_bus),
		.out_req   (out_bus)
	);

	// Shadow of the bank state and registers
	logic [31:0] osc_phase [mlb_pkg::VOICES];
	bit          osc_latch [mlb_pkg::VOICES];
	bit          bip_shadow;
	logic [22:0] inc_shadow;

	tick_t  pending_ticks[$];
	level_t expected_levels[$];
	tick_t  cur_tick;
	bit     drv_busy;
	bit     in_fire;
	int     burst_left, gap_left;
	int     mismatches;
	int     accepted_ticks;
	int     idle_cycles;

	// Clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Expected level for one tick; advances the shadow phase and latch
	function automatic logic signed [15:0] lfo_level(input tick_t t);
		int     pitch, pu, k, shape_c, pw_c, span, w, ui, qi, di, quad, sx;
		logic [63:0] ratio, prod, delta;
		logic [31:0] ph, ps;
		logic [15:0] q16;
		longint x2, inner, mid, s, sum, x;
		longint waves[4];
		if (t.voice >= mlb_pkg::VOICES)
			return '0;
		// Schmitt reset: phase cleared on the rising edge only
		if (t.rst_mv >= 2000) begin
			if (!osc_latch[t.voice])
				osc_phase[t.voice] = '0;
			osc_latch[t.voice] = 1'b1;
		end else if (t.rst_mv <= 100) begin
			osc_latch[t.voice] = 1'b0;
		end
		// Exponential step, limited to half a cycle
		pitch = int'(t.pitch);
		if (pitch > 40960)
			pitch = 40960;
		pu = pitch + 131072;
		k = (pu >> 12) - 32;
		ratio = 64'd1 << 30;
		for (int b = 0; b < 12; b++)
			if (pu[b])
				ratio = (ratio * {32'd0, mlb_pkg::ROOTS[b*32 +: 32]} + (64'd1 << 29)) >> 30;
		prod = {41'd0, inc_shadow} * ratio;
		delta = prod >> (30 - k);
		if (delta > (64'd1 << 31))
			delta = 64'd1 << 31;
		osc_phase[t.voice] = osc_phase[t.voice] + delta[31:0];
		ph = osc_phase[t.voice] + {t.offs, 16'h0000};
		ui = int'(ph[31:16]);
		// Sine from the quantised phase, quarter-wave polynomial
		ps = bip_shadow ? ph : ph - 32'h4000_0000;
		quad = int'(ps[31:30]);
		sx = int'({ps[29:22], 7'd0});
		if (quad[0])
			sx = 32768 - sx;
		x2 = (longint'(sx) * sx) >> 15;
		inner = 21024 - ((x2 * 2320) >> 15);
		mid = 51472 - ((x2 * inner) >> 15);
		s = (longint'(sx) * mid) >> 15;
		waves[0] = quad[1] ? -s : s;
		// Triangle
		q16 = bip_shadow ? ph[31:16] + 16'd16384 : ph[31:16];
		qi = int'(q16);
		di = (qi <= 32768) ? qi : 65536 - qi;
		waves[1] = longint'(2 * di - 32768);
		// Saw
		if (bip_shadow)
			waves[2] = longint'((ui < 32768) ? ui : ui - 65536);
		else
			waves[2] = longint'(ui - 32768);
		// Square with clamped duty
		pw_c = int'(t.pw);
		if (pw_c < 655)
			pw_c = 655;
		if (pw_c > 64880)
			pw_c = 64880;
		waves[3] = (ui < pw_c) ? 64'sd32768 : -64'sd32768;
		// Triangular morph weights
		shape_c = (t.shape > 3072) ? 3072 : int'(t.shape);
		sum = 0;
		for (int i = 0; i < 4; i++) begin
			span = shape_c - 1024 * i;
			if (span < 0)
				span = -span;
			w = 1024 - span;
			if (w > 0)
				sum += longint'(w) * (bip_shadow ? waves[i] : waves[i] + 32768);
		end
		x = (sum * 5 + 8192) >>> 14;
		return x[15:0];
	endfunction

	function automatic tick_t random_tick();
		tick_t t;
		int sel;
		t.voice = 4'($urandom_range(0, 15));
		sel = $urandom_range(0, 9);
		if (sel < 6)
			t.pitch = 18'($urandom_range(0, 122880) - 81920);
		else if (sel < 8)
			t.pitch = 18'(40960 - $urandom_range(0, 12288));
		else
			t.pitch = 18'($urandom);
		t.shape = 12'($urandom);
		t.pw    = 16'($urandom);
		t.offs  = (sel < 5) ? 16'd0 : 16'($urandom);
		sel = $urandom_range(0, 9);
		if (sel < 7)
			t.rst_mv = 15'($urandom_range(0, 10100) - 10000);
		else if (sel < 9)
			t.rst_mv = 15'($urandom_range(2000, 16383));
		else
			t.rst_mv = 15'($urandom);
		return t;
	endfunction

	// Request driver: bursts with random gaps
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_bus.valid <= 1'b0;
			drv_busy = 1'b0;
			burst_left = 1;
			gap_left = 0;
		end else begin
			if (drv_busy && in_fire)
				drv_busy = 1'b0;
			if (!drv_busy) begin
				if (gap_left > 0) begin
					gap_left--;
					in_bus.valid <= 1'b0;
				end else if (pending_ticks.size() > 0) begin
					cur_tick = pending_ticks.pop_front();
					in_bus.voice         <= cur_tick.voice;
					in_bus.pitch_octaves <= cur_tick.pitch;
					in_bus.wave_shape    <= cur_tick.shape;
					in_bus.pulse_width   <= cur_tick.pw;
					in_bus.phase_offset  <= cur_tick.offs;
					in_bus.reset_level   <= cur_tick.rst_mv;
					in_bus.valid <= 1'b1;
					drv_busy = 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 30);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
					end
				end else begin
					in_bus.valid <= 1'b0;
				end
			end
		end
	end

	// Result receiver: stall pattern plus one long hold-off
	int  rx_seg, rx_mode, rx_hold;
	bit  rx_hold_done;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_bus.ready <= 1'b0;
			rx_seg = 0;
			rx_mode = 0;
			rx_hold = 0;
			rx_hold_done = 1'b0;
		end else begin
			if (!rx_hold_done && accepted_ticks >= 150) begin
				rx_hold = 400;
				rx_hold_done = 1'b1;
			end
			if (rx_seg == 0) begin
				rx_seg = $urandom_range(5, 80);
				rx_mode = $urandom_range(0, 2);
			end
			rx_seg--;
			if (rx_hold > 0) begin
				rx_hold--;
				out_bus.ready <= 1'b0;
			end else if (rx_mode == 0)
				out_bus.ready <= 1'b1;
			else if (rx_mode == 1)
				out_bus.ready <= 1'($urandom_range(0, 1));
			else
				out_bus.ready <= ($urandom_range(0, 4) == 0);
		end
	end

	// Request acceptance: predict the level
	always @(posedge clk or negedge arst_n) begin
		level_t e;
		tick_t  t;
		if (!arst_n) begin
			in_fire <= 1'b0;
		end else begin
			in_fire <= in_bus.valid && in_bus.ready;
			if (in_bus.valid && in_bus.ready) begin
				t.voice  = in_bus.voice;
				t.pitch  = in_bus.pitch_octaves;
				t.shape  = in_bus.wave_shape;
				t.pw     = in_bus.pulse_width;
				t.offs   = in_bus.phase_offset;
				t.rst_mv = in_bus.reset_level;
				e.voice = t.voice;
				e.level = lfo_level(t);
				expected_levels.push_back(e);
				accepted_ticks++;
			end
		end
	end

	// Result check against the oldest expectation
	always @(posedge clk) begin
		level_t e;
		if (arst_n && out_bus.valid && out_bus.ready) begin
			if (expected_levels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: voice %0d level %0d",
						out_bus.voice_out, out_bus.level);
			end else begin
				e = expected_levels.pop_front();
				if (e.voice !== out_bus.voice_out || e.level !== out_bus.level) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp voice %0d level %0d, got voice %0d level %0d",
							e.voice, e.level, out_bus.voice_out, out_bus.level);
				end
			end
		end
	end

	// Watchdog on cycles with no handshake
	always @(posedge clk) begin
		if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic write_reg(input logic [mlb_pkg::CFG_IDX_W-1:0] idx, input logic [22:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		if (idx == mlb_pkg::CFG_BIPOLAR)
			bip_shadow = val[0];
		else
			inc_shadow = val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (pending_ticks.size() > 0 || drv_busy || expected_levels.size() > 0)
			@(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	// Stimulus sequence
	initial begin
		tick_t t;
		int rst_seq[8] = '{0, 2000, 1999, 100, 2001, 101, -16384, 16383};
		int pitch_dir[6] = '{-131072, -81920, 0, 40960, 40961, 131071};
		int shape_dir[7] = '{0, 1024, 2048, 3072, 3073, 4095, 512};
		int pw_dir[6] = '{0, 654, 655, 64880, 64881, 65535};
		int offs_dir[3] = '{0, 65535, 32768};
		logic [22:0] inc_set[4] = '{23'd1, 23'd4294967, 23'd0, 23'd0};
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mismatches = 0;
		accepted_ticks = 0;
		idle_cycles = 0;
		bip_shadow = 1'b0;
		inc_shadow = mlb_pkg::INC_RESET;
		for (int i = 0; i < mlb_pkg::VOICES; i++) begin
			osc_phase[i] = '0;
			osc_latch[i] = 1'b1;
		end
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: field extremes and reset thresholds at reset configuration
		for (int i = 0; i < 24; i++) begin
			t.voice  = (i < 16) ? 4'(i / 8) : 4'(15 - i);
			t.pitch  = 18'(pitch_dir[i % 6]);
			t.shape  = 12'(shape_dir[i % 7]);
			t.pw     = 16'(pw_dir[i % 6]);
			t.offs   = 16'(offs_dir[i % 3]);
			t.rst_mv = 15'(rst_seq[i % 8]);
			pending_ticks.push_back(t);
		end
		drain();

		// Random phases across register settings
		inc_set[2] = 23'($urandom_range(1, 4294967));
		inc_set[3] = 23'($urandom_range(1000, 200000));
		for (int ph = 0; ph < 5; ph++) begin
			if (ph > 0) begin
				write_reg(mlb_pkg::CFG_BIPOLAR, 23'(ph % 2));
				write_reg(mlb_pkg::CFG_INC, inc_set[ph - 1]);
			end
			for (int i = 0; i < 80; i++)
				pending_ticks.push_back(random_tick());
			drain();
		end

		repeat (40) @(posedge clk);
		if (mismatches == 0 && expected_levels.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

/* sim.f */
sv/mlb_pkg.sv
sv/mlb_in_if.sv
sv/mlb_out_if.sv
sv/mlb_exp2.sv
sv/morphing_lfo_bank.sv
tb/morphing_lfo_bank_tb.sv
